FILE: hw/rtl/sfcc_pkg.sv
// Types, constants and helper functions shared by the sensor frame check/convert block.
// No dependencies; compiled first.
package sfcc_pkg;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_BUS = 2'd1,
      STATUS_CRC = 2'd2
   } status_type;

   // byte positions within a response frame
   localparam logic [2:0] POS_A_HI  = 3'd0;
   localparam logic [2:0] POS_A_LO  = 3'd1;
   localparam logic [2:0] POS_A_CRC = 3'd2;
   localparam logic [2:0] POS_B_HI  = 3'd3;
   localparam logic [2:0] POS_B_LO  = 3'd4;
   localparam logic [2:0] POS_B_CRC = 3'd5;

   localparam logic [7:0] CRC_POLY = 8'h31;  // x^8+x^5+x^4+1, top bit implied
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [14:0] TEMP_SPAN   = 15'd17500;
   localparam logic [9:0]  HUM_SPAN    = 10'd1000;
   localparam logic [15:0] RECIP_TEN   = 16'd52429;  // 2^19 / 10, rounded up
   localparam int          RECIP_SHIFT = 19;
   localparam logic [3:0]  ROUND_HALF  = 4'd5;
   localparam logic signed [11:0] TEMP_OFFSET = 12'sd450;

   typedef struct packed {
      status_type  status;
      logic [15:0] first_word;
      logic [15:0] second_word;
   } frame_result_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535), exact for x < 2^32 - 1
   function automatic logic [16:0] div_65535(input logic [31:0] x);
      logic [32:0] sum;
      sum = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
      return sum[32:16];
   endfunction

endpackage

FILE: hw/rtl/sfcc_if.sv
// Valid/ready channel interfaces for request bytes and converted results.
// Depends on sfcc_pkg.
interface sfcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;
   logic       bus_error;

   modport source(output valid, rx_byte, frame_start, bus_error, input ready);
   modport sink(input valid, rx_byte, frame_start, bus_error, output ready);
endinterface

interface sfcc_rsp_if;
   import sfcc_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [15:0]        raw_temperature;
   logic [15:0]        raw_humidity;
   logic [31:0]        serial_number;
   logic signed [11:0] temperature_tenths;
   logic [6:0]         humidity_percent;

   modport source(output valid, status, raw_temperature, raw_humidity, serial_number,
                  temperature_tenths, humidity_percent, input ready);
   modport sink(input valid, status, raw_temperature, raw_humidity, serial_number,
                temperature_tenths, humidity_percent, output ready);
endinterface

FILE: hw/rtl/sfcc_frame.sv
// Frame tracker: byte position, per-word CRC-8 check and word assembly.
// Depends on sfcc_pkg.
module sfcc_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                rx_byte,
   input  logic                      frame_start,
   input  logic                      bus_error,
   output logic                      result_valid,
   output sfcc_pkg::frame_result_type result
);
   import sfcc_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic        failed_ff, failed_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] second_ff, second_in;

   logic       restart;
   logic [2:0] pos_eff;
   logic [7:0] crc_eff;
   logic       failed_eff;

   always_comb begin
      restart    = frame_start || (pos_ff > POS_B_CRC);
      pos_eff    = restart ? POS_A_HI : pos_ff;
      crc_eff    = restart ? CRC_INIT : crc_ff;
      failed_eff = restart ? 1'b0 : failed_ff;

      pos_in       = pos_eff + 3'd1;
      crc_in       = crc_eff;
      failed_in    = failed_eff;
      first_in     = first_ff;
      second_in    = second_ff;
      result_valid = 1'b0;
      result       = '{status: STATUS_OK, first_word: first_ff, second_word: second_ff};

      if (bus_error) begin
         pos_in       = POS_A_HI;
         crc_in       = CRC_INIT;
         failed_in    = 1'b0;
         result_valid = 1'b1;
         result       = '{status: STATUS_BUS, first_word: 16'd0, second_word: 16'd0};
      end else begin
         case (pos_eff)
            POS_A_HI: begin
               crc_in   = crc8_byte(CRC_INIT, rx_byte);
               first_in = {rx_byte, first_ff[7:0]};
            end
            POS_A_LO: begin
               crc_in   = crc8_byte(crc_eff, rx_byte);
               first_in = {first_ff[15:8], rx_byte};
            end
            POS_B_HI: begin
               crc_in    = crc8_byte(CRC_INIT, rx_byte);
               second_in = {rx_byte, second_ff[7:0]};
            end
            POS_B_LO: begin
               crc_in    = crc8_byte(crc_eff, rx_byte);
               second_in = {second_ff[15:8], rx_byte};
            end
            default: begin
               if (crc_eff != rx_byte) begin
                  failed_in = 1'b1;
               end
               crc_in = CRC_INIT;
            end
         endcase
         if (pos_eff == POS_B_CRC) begin
            result_valid  = 1'b1;
            result.status = failed_in ? STATUS_CRC : STATUS_OK;
            if (failed_in) begin
               result.first_word  = 16'd0;
               result.second_word = 16'd0;
            end
            pos_in        = POS_A_HI;
            crc_in        = CRC_INIT;
            failed_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_A_HI;
         crc_ff    <= CRC_INIT;
         failed_ff <= 1'b0;
         first_ff  <= 16'd0;
         second_ff <= 16'd0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         failed_ff <= failed_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

FILE: hw/rtl/sfcc_convert.sv
// Conversion pipeline: scaling of raw words to tenths of a degree and percent,
// with the output register. Depends on sfcc_pkg, sfcc_if.
module sfcc_convert (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  sfcc_pkg::frame_result_type in_data,
   output logic                       advance,
   sfcc_rsp_if.source                 rsp_bus
);
   import sfcc_pkg::*;

   frame_result_type s1_ff, s2_ff, s3_ff;
   logic             v1_ff, v2_ff, v3_ff;
   logic [30:0]      tprod_ff, tprod_in;
   logic [25:0]      hprod_ff, hprod_in;
   logic [30:0]      tq_ff, tq_in;
   logic [26:0]      hq_ff, hq_in;

   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic [15:0]        rawt_ff, rawh_ff;
   logic signed [11:0] temp_ff, temp_in;
   logic [6:0]         hum_ff, hum_in;

   logic [16:0] t_div, h_div;
   logic [14:0] t100;
   logic [9:0]  h10;
   logic        ok3;

   assign advance = !rsp_valid_ff || rsp_bus.ready;

   // stage 2: products
   assign tprod_in = 31'(s1_ff.first_word) * 31'(TEMP_SPAN);
   assign hprod_in = 26'(s1_ff.second_word) * 26'(HUM_SPAN);

   // stage 3: divide by 65535, round, times 1/10
   assign t_div = div_65535({1'b0, tprod_ff});
   assign h_div = div_65535({6'd0, hprod_ff});
   assign t100  = t_div[14:0];
   assign h10   = h_div[9:0];
   assign tq_in = (31'(t100) + 31'(ROUND_HALF)) * 31'(RECIP_TEN);
   assign hq_in = (27'(h10) + 27'(ROUND_HALF)) * 27'(RECIP_TEN);

   // output stage
   assign ok3       = (s3_ff.status == STATUS_OK);
   assign status_in = s3_ff.status;
   assign temp_in   = ok3 ? ($signed({1'b0, tq_ff[RECIP_SHIFT+10:RECIP_SHIFT]}) - TEMP_OFFSET)
                          : 12'sd0;
   assign hum_in    = ok3 ? hq_ff[RECIP_SHIFT+6:RECIP_SHIFT] : 7'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff     <= in_data;
         s2_ff     <= s1_ff;
         tprod_ff  <= tprod_in;
         hprod_ff  <= hprod_in;
         s3_ff     <= s2_ff;
         tq_ff     <= tq_in;
         hq_ff     <= hq_in;
         status_ff <= status_in;
         rawt_ff   <= s3_ff.first_word;
         rawh_ff   <= s3_ff.second_word;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.status             = status_ff;
   assign rsp_bus.raw_temperature    = rawt_ff;
   assign rsp_bus.raw_humidity       = rawh_ff;
   assign rsp_bus.serial_number      = {rawt_ff, rawh_ff};
   assign rsp_bus.temperature_tenths = temp_ff;
   assign rsp_bus.humidity_percent   = hum_ff;

endmodule

FILE: hw/rtl/sensor_frame_check_convert_top.sv
// Top level of the sensor frame check/convert block.
// Depends on sfcc_pkg, sfcc_if, sfcc_frame, sfcc_convert.
//
//   channel   dir  modport  transaction
//   req_bus   in   sink     one response byte with frame_start / bus_error flags
//   rsp_bus   out  source   one result per completed frame or bus error
//
// One byte accepted per cycle while req_bus.ready is high. A result is carried from the
// byte that completes it (sixth byte or bus error) through the input, multiply,
// divide/round and output stages, and leaves the output register when rsp_bus.ready is high.
// While a result waits in the output register the whole pipeline holds and
// req_bus.ready drops. Synchronous reset clears frame state and valid bits.
module sensor_frame_check_convert_top (
   input logic        clock,
   input logic        reset,
   sfcc_req_if.sink   req_bus,
   sfcc_rsp_if.source rsp_bus
);
   import sfcc_pkg::*;

   logic             advance;
   logic             accept;
   logic             frame_valid;
   frame_result_type frame_result;

   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   sfcc_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_bus.rx_byte),
      .frame_start  (req_bus.frame_start),
      .bus_error    (req_bus.bus_error),
      .result_valid (frame_valid),
      .result       (frame_result)
   );

   sfcc_convert u_convert (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept && frame_valid),
      .in_data  (frame_result),
      .advance  (advance),
      .rsp_bus  (rsp_bus)
   );

endmodule
